// File: hw/rtl/u16u8_pkg.sv
// Shared types, constants and byte-encoding helpers for the UTF-16 to UTF-8 transcoder.
// Used by the front end, the command queue, the byte sequencer and the top level.
package u16u8_pkg;

  localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
  localparam logic [20:0] REPLACEMENT_CP  = 21'h00FFFD;
  localparam logic [20:0] SUPP_BASE       = 21'h010000;
  localparam logic [20:0] ONE_BYTE_MAX    = 21'h00007F;
  localparam logic [20:0] TWO_BYTE_MAX    = 21'h0007FF;
  localparam logic [20:0] THREE_BYTE_MAX  = 21'h00FFFF;
  localparam logic [7:0]  LEAD2_MARK      = 8'hC0;
  localparam logic [7:0]  LEAD3_MARK      = 8'hE0;
  localparam logic [7:0]  LEAD4_MARK      = 8'hF0;
  localparam logic [7:0]  CONT_MARK       = 8'h80;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_word_t;

  // One command per input unit that yields bytes: an optional leading U+FFFD
  // for a dropped high surrogate, then an optional code point.
  typedef struct packed {
    logic        lead_repl;
    logic        has_point;
    logic [20:0] point;
    logic        last;
  } cmd_t;

  // Number of UTF-8 bytes for a code point, minus one.
  function automatic logic [1:0] byte_count_m1(input logic [20:0] cp);
    logic [1:0] n;
    if (cp <= ONE_BYTE_MAX) begin
      n = 2'd0;
    end else if (cp <= TWO_BYTE_MAX) begin
      n = 2'd1;
    end else if (cp <= THREE_BYTE_MAX) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  // Byte number idx of the encoding of cp, where n is the byte count minus one.
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx,
                                           input logic [1:0] n);
    logic [7:0] b;
    b = CONT_MARK | {2'b00, cp[5:0]};
    case (n)
      2'd0: b = cp[7:0];
      2'd1: begin
        case (idx)
          2'd0:    b = LEAD2_MARK | {3'b000, cp[10:6]};
          default: b = CONT_MARK | {2'b00, cp[5:0]};
        endcase
      end
      2'd2: begin
        case (idx)
          2'd0:    b = LEAD3_MARK | {4'b0000, cp[15:12]};
          2'd1:    b = CONT_MARK | {2'b00, cp[11:6]};
          default: b = CONT_MARK | {2'b00, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = LEAD4_MARK | {5'b00000, cp[20:18]};
          2'd1:    b = CONT_MARK | {2'b00, cp[17:12]};
          2'd2:    b = CONT_MARK | {2'b00, cp[11:6]};
          default: b = CONT_MARK | {2'b00, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/u16u8_front.sv
// Front end: accepts UTF-16 code units, pairs surrogates and classifies each unit.
// Depends on u16u8_pkg; pushes commands into the command queue.
module u16u8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  u16u8_pkg::in_word_t in_word,
  input  logic                q_full,
  output logic                in_stall,
  output logic                push,
  output u16u8_pkg::cmd_t     push_cmd
);

  logic       held_valid_r, held_valid_nxt;
  logic [9:0] held_bits_r, held_bits_nxt;
  logic       accept;
  logic       is_high, is_low;
  logic [15:0] unit;
  logic        last;

  assign unit     = in_word.code_unit;
  assign last     = in_word.last_unit;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign is_high = unit inside {[u16u8_pkg::HIGH_SURR_FIRST:u16u8_pkg::HIGH_SURR_LAST]};
  assign is_low  = unit inside {[u16u8_pkg::LOW_SURR_FIRST:u16u8_pkg::LOW_SURR_LAST]};

  always_comb begin
    push_cmd.lead_repl = 1'b0;
    push_cmd.has_point = 1'b1;
    push_cmd.point     = {5'd0, unit};
    push_cmd.last      = last;
    held_valid_nxt     = 1'b0;
    held_bits_nxt      = 10'd0;
    if (held_valid_r && is_low) begin
      // Complete surrogate pair.
      push_cmd.point = u16u8_pkg::SUPP_BASE + {1'b0, held_bits_r, unit[9:0]};
    end else begin
      push_cmd.lead_repl = held_valid_r;
      if (is_high) begin
        if (last) begin
          push_cmd.point = u16u8_pkg::REPLACEMENT_CP;
        end else begin
          push_cmd.has_point = 1'b0;
          held_valid_nxt     = 1'b1;
          held_bits_nxt      = unit[9:0];
        end
      end else if (is_low) begin
        push_cmd.point = u16u8_pkg::REPLACEMENT_CP;
      end
    end
    push = accept && (push_cmd.lead_repl || push_cmd.has_point);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_bits_r  <= 10'd0;
    end else if (accept) begin
      held_valid_r <= held_valid_nxt;
      held_bits_r  <= held_bits_nxt;
    end
  end

endmodule

// File: hw/rtl/u16u8_cmd_fifo.sv
// Two-entry command queue between the front end and the byte sequencer.
// Depends on u16u8_pkg for the command type.
module u16u8_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u16u8_pkg::cmd_t push_cmd,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output u16u8_pkg::cmd_t head
);

  u16u8_pkg::cmd_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: hw/rtl/u16u8_back.sv
// Byte sequencer: turns queued commands into UTF-8 bytes, one per cycle while the output is not stalled.
// Depends on u16u8_pkg; drives the registered output word.
module u16u8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  u16u8_pkg::cmd_t      q_head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output u16u8_pkg::out_word_t out_word
);

  logic        busy_r, busy_nxt;
  logic [20:0] pt_r, pt_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [1:0]  n_r, n_nxt;
  logic        second_valid_r, second_valid_nxt;
  logic [20:0] second_pt_r, second_pt_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  u16u8_pkg::out_word_t out_word_r, out_word_nxt;
  logic        emit, point_done, cmd_done;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    emit       = busy_r && (!out_valid_r || !out_stall);
    point_done = (idx_r == n_r);
    cmd_done   = point_done && !second_valid_r;
    pop        = q_not_empty && (!busy_r || (emit && cmd_done));

    busy_nxt         = busy_r;
    pt_nxt           = pt_r;
    idx_nxt          = idx_r;
    n_nxt            = n_r;
    second_valid_nxt = second_valid_r;
    second_pt_nxt    = second_pt_r;
    last_nxt         = last_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_word_nxt     = out_word_r;

    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_word_nxt.out_byte   = u16u8_pkg::utf8_byte(pt_r, idx_r, n_r);
      out_word_nxt.run_last   = cmd_done;
      out_word_nxt.string_end = cmd_done && last_r;
      if (!point_done) begin
        idx_nxt = idx_r + 2'd1;
      end else if (second_valid_r) begin
        pt_nxt           = second_pt_r;
        n_nxt            = u16u8_pkg::byte_count_m1(second_pt_r);
        idx_nxt          = 2'd0;
        second_valid_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b0;
      end
    end

    if (pop) begin
      busy_nxt      = 1'b1;
      idx_nxt       = 2'd0;
      last_nxt      = q_head.last;
      second_pt_nxt = q_head.point;
      if (q_head.lead_repl) begin
        pt_nxt           = u16u8_pkg::REPLACEMENT_CP;
        second_valid_nxt = q_head.has_point;
      end else begin
        pt_nxt           = q_head.point;
        second_valid_nxt = 1'b0;
      end
      n_nxt = u16u8_pkg::byte_count_m1(pt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    pt_r        <= pt_nxt;
    idx_r       <= idx_nxt;
    n_r         <= n_nxt;
    second_pt_r <= second_pt_nxt;
    last_r      <= last_nxt;
    out_word_r  <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b0;
      second_valid_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      busy_r         <= busy_nxt;
      second_valid_r <= second_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/utf16_to_utf8_transcoder_unit.sv
// UTF-16 to UTF-8 transcoder, top level.
// Depends on u16u8_pkg, u16u8_front, u16u8_cmd_fifo and u16u8_back.
//
// Usage: the input channel (in_valid, in_word, in_stall) takes one UTF-16
// code unit per word together with a mark for the last unit of a string.
// The output channel (out_valid, out_word, out_stall) gives one UTF-8 byte
// per word; run_last flags the final byte caused by one input word and
// string_end the final byte of the string. A high surrogate that is not
// last yields no bytes until the next word decides its fate; unpaired
// surrogates come out as U+FFFD.
// The front end classifies each word in the cycle it is accepted and puts
// a command into a two-entry queue. The byte sequencer pops commands and
// sends one byte per cycle while the output is not stalled. An input word
// yields no bytes for a held high surrogate, one to four for a unit on its
// own, up to six when the U+FFFD of a dropped high surrogate comes before
// the new unit's bytes. The single output byte per cycle sets the sustained
// rate. Synchronous reset clears the held surrogate, the queue and the
// output valid flag. A stalled output holds its word; the queue then
// fills and in_stall rises while the front end waits.
module utf16_to_utf8_transcoder_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  u16u8_pkg::in_word_t  in_word,
  output logic                 in_stall,
  output logic                 out_valid,
  output u16u8_pkg::out_word_t out_word,
  input  logic                 out_stall
);

  logic            push, pop, q_full, q_not_empty;
  u16u8_pkg::cmd_t push_cmd, q_head;

  u16u8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .push_cmd (push_cmd)
  );

  u16u8_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  u16u8_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule
